@@ hw/rtl/schpd_pkg.sv @@
// schpd_pkg: shared types, constants and the crc-8 update function of the deframer
`timescale 1ns / 1ps

package schpd_pkg;

    localparam logic [7:0] SYNC_RESET  = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [2:0] HEADER_LAST = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_CRC     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_HDR_ERR  = 3'd2,
        KIND_DATA_ERR = 3'd3,
        KIND_EMPTY    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        in_optional;
        logic [16:0] byte_index;
        logic [7:0]  packet_type;
        logic [15:0] data_length;
        logic [7:0]  optional_length;
    } result_t;

    // msb first, no reflection, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/schpd_parser.sv @@
// schpd_parser: framing state machine, header capture and crc checks, one byte per cycle while byte_fire is high
`timescale 1ns / 1ps

module schpd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                byte_fire,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output schpd_pkg::result_t  res
);
    import schpd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] data_length_reg, data_length_next;
    logic [7:0]  optional_length_reg, optional_length_next;
    logic [7:0]  packet_type_reg, packet_type_next;
    logic [16:0] payload_count_reg, payload_count_next;
    logic [7:0]  sync_value_reg;

    logic [7:0]  crc_step;
    logic [16:0] total_len;
    logic [16:0] count_inc;
    logic        header_empty;

    assign crc_step     = crc8_update(crc_reg, rx_byte);
    assign total_len    = {1'b0, data_length_reg} + {9'd0, optional_length_reg};
    assign count_inc    = payload_count_reg + 17'd1;
    assign header_empty = (total_len == 17'd0);

    // next state and datapath
    always_comb
    begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        crc_next             = crc_reg;
        data_length_next     = data_length_reg;
        optional_length_next = optional_length_reg;
        packet_type_next     = packet_type_reg;
        payload_count_next   = payload_count_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                if (header_count_reg < HEADER_LAST)
                begin
                    case (header_count_reg)
                        3'd0:    data_length_next = {rx_byte, 8'h00};
                        3'd1:    data_length_next = {data_length_reg[15:8], rx_byte};
                        3'd2:    optional_length_next = rx_byte;
                        default: packet_type_next = rx_byte;
                    endcase
                    crc_next          = crc_step;
                    header_count_next = header_count_reg + 3'd1;
                end
                else
                begin
                    header_count_next = 3'd0;
                    if ((rx_byte == crc_reg) && !header_empty)
                    begin
                        phase_next         = PH_PAYLOAD;
                        crc_next           = 8'h00;
                        payload_count_next = 17'd0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                crc_next           = crc_step;
                payload_count_next = count_inc;
                if (count_inc >= total_len)
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                if (rx_byte == sync_value_reg)
                begin
                    phase_next        = PH_HEADER;
                    header_count_next = 3'd0;
                    crc_next          = 8'h00;
                end
            end
        endcase
    end

    // result for the current byte
    always_comb
    begin
        res_valid           = 1'b0;
        res.kind            = KIND_PAYLOAD;
        res.payload_byte    = 8'h00;
        res.in_optional     = 1'b0;
        res.byte_index      = 17'd0;
        res.packet_type     = packet_type_next;
        res.data_length     = data_length_next;
        res.optional_length = optional_length_next;
        case (phase_reg)
            PH_HEADER:
            begin
                if (header_count_reg == HEADER_LAST)
                begin
                    if (rx_byte != crc_reg)
                    begin
                        res_valid = byte_fire;
                        res.kind  = KIND_HDR_ERR;
                    end
                    else if (header_empty)
                    begin
                        res_valid = byte_fire;
                        res.kind  = KIND_EMPTY;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                res_valid        = byte_fire;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.in_optional  = (payload_count_reg >= {1'b0, data_length_reg});
                res.byte_index   = payload_count_reg;
            end
            PH_CRC:
            begin
                res_valid = byte_fire;
                res.kind  = (rx_byte == crc_reg) ? KIND_GOOD : KIND_DATA_ERR;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HUNT;
            header_count_reg    <= 3'd0;
            crc_reg             <= 8'h00;
            data_length_reg     <= 16'd0;
            optional_length_reg <= 8'd0;
            packet_type_reg     <= 8'd0;
            payload_count_reg   <= 17'd0;
        end
        else if (byte_fire)
        begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            crc_reg             <= crc_next;
            data_length_reg     <= data_length_next;
            optional_length_reg <= optional_length_next;
            packet_type_reg     <= packet_type_next;
            payload_count_reg   <= payload_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= SYNC_RESET;
        end
        else if (cfg_we)
        begin
            sync_value_reg <= cfg_wdata;
        end
    end

endmodule

@@ hw/rtl/schpd_out_buf.sv @@
// schpd_out_buf: result register with a skid stage; the input waits only while the skid stage is full
`timescale 1ns / 1ps

module schpd_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  schpd_pkg::result_t  res,
    output logic                res_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output schpd_pkg::result_t  out_res
);
    import schpd_pkg::*;

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    assign res_ready = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid && !skid_valid_reg)
        begin
            skid_reg <= res;
        end
    end

endmodule

@@ hw/rtl/sync_header_crc8_packet_deframer_core.sv @@
// sync_header_crc8_packet_deframer_core: top level of the serial packet deframer
`timescale 1ns / 1ps

// takes one received byte per item on the slave side and hunts for the sync byte
// (cfg register, 0x55 after reset). after sync it collects a 4-byte header
// (data length high byte first, optional length, packet type) and a crc-8 byte
// (poly 0x07, init 0, msb first). with a good header every data and optional byte
// goes out as a payload item with its index, then the trailing crc-8 byte gives a
// good or data-error item. a header crc mismatch gives a header-error item and a
// zero total length an empty-packet item; every end returns to the sync hunt.
// one byte is taken every cycle while the skid stage is free: the crc-8 step
// and framing decode sit between the state registers and the result register,
// and a skid stage behind the result register keeps the input open for one
// more item while a result waits.

module sync_header_crc8_packet_deframer_core (
    input  logic        clk,
    input  logic        rst_n,
    // sync byte register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [7:0] payload_byte, [24:8] byte_index,
                                   // [32:25] packet_type, [48:33] data_length,
                                   // [56:49] optional_length, rest zero
    output logic [3:0]  m_tuser    // [2:0] kind, [3] in_optional
);
    import schpd_pkg::*;

    logic    byte_fire;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_res;

    // a byte is taken whenever the skid stage is free
    assign s_tready  = res_ready;
    assign byte_fire = s_tvalid && s_tready;

    schpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .byte_fire (byte_fire),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    schpd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack result fields onto the stream
    assign m_tdata = {7'd0, out_res.optional_length, out_res.data_length,
                      out_res.packet_type, out_res.byte_index, out_res.payload_byte};
    assign m_tuser = {out_res.in_optional, out_res.kind};

endmodule

@@ bench/deframer_result_checker.sv @@
// deframer_result_checker: predicts the deframer's result items and compares them as they leave
`timescale 1ns / 1ps

module deframer_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int          mismatch_count,
    output int          pending_count,
    output int          results_seen
);

    import schpd_pkg::*;

    // own copy of the deframer state
    logic [7:0]  sync_byte;
    phase_t      stage;
    logic [2:0]  hdr_count;
    logic [7:0]  crc_acc;
    logic [15:0] held_dlen;
    logic [7:0]  held_olen;
    logic [7:0]  held_ptype;
    logic [16:0] pay_count;

    result_t     awaited_results[$];

    // serial form of the crc-8: feedback bit taken per data bit
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] pb,
                                            input logic opt, input logic [16:0] ix);
        result_t r;
        r.kind            = k;
        r.payload_byte    = pb;
        r.in_optional     = opt;
        r.byte_index      = ix;
        r.packet_type     = held_ptype;
        r.data_length     = held_dlen;
        r.optional_length = held_olen;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output bit produced, output result_t r);
        logic [16:0] span;
        span     = {1'b0, held_dlen} + {9'b0, held_olen};
        produced = 1'b0;
        r        = '0;
        case (stage)
            PH_HEADER:
            begin
                if (hdr_count < HEADER_LAST)
                begin
                    case (hdr_count)
                        3'd0:    held_dlen = {b, 8'h00};
                        3'd1:    held_dlen[7:0] = b;
                        3'd2:    held_olen = b;
                        default: held_ptype = b;
                    endcase
                    crc_acc   = crc8_next(crc_acc, b);
                    hdr_count = hdr_count + 3'd1;
                end
                else
                begin
                    stage     = PH_HUNT;
                    hdr_count = '0;
                    if (b != crc_acc)
                    begin
                        r        = make_result(KIND_HDR_ERR, 8'h00, 1'b0, 17'd0);
                        produced = 1'b1;
                    end
                    else if (span == 17'd0)
                    begin
                        r        = make_result(KIND_EMPTY, 8'h00, 1'b0, 17'd0);
                        produced = 1'b1;
                    end
                    else
                    begin
                        stage     = PH_PAYLOAD;
                        crc_acc   = '0;
                        pay_count = '0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                r = make_result(KIND_PAYLOAD, b, pay_count >= {1'b0, held_dlen}, pay_count);
                produced  = 1'b1;
                crc_acc   = crc8_next(crc_acc, b);
                pay_count = pay_count + 17'd1;
                if (pay_count >= span)
                begin
                    stage = PH_CRC;
                end
            end
            PH_CRC:
            begin
                stage    = PH_HUNT;
                r        = make_result((b == crc_acc) ? KIND_GOOD : KIND_DATA_ERR,
                                       8'h00, 1'b0, 17'd0);
                produced = 1'b1;
            end
            default:
            begin
                stage = PH_HUNT;
                if (b == sync_byte)
                begin
                    stage     = PH_HEADER;
                    hdr_count = '0;
                    crc_acc   = '0;
                end
            end
        endcase
    endtask

    task automatic compare_result(input result_t got, input logic [6:0] pad);
        result_t exp;
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t unexpected result: kind %0d byte %02h opt %0b idx %0d type %02h len %0d/%0d",
                         $time, got.kind, got.payload_byte, got.in_optional, got.byte_index,
                         got.packet_type, got.data_length, got.optional_length);
            end
        end
        else
        begin
            exp = awaited_results.pop_front();
            if (got.kind !== exp.kind || got.payload_byte !== exp.payload_byte ||
                got.in_optional !== exp.in_optional || got.byte_index !== exp.byte_index ||
                got.packet_type !== exp.packet_type || got.data_length !== exp.data_length ||
                got.optional_length !== exp.optional_length || pad !== 7'd0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t result mismatch: expected kind %0d byte %02h opt %0b idx %0d type %02h len %0d/%0d",
                             $time, exp.kind, exp.payload_byte, exp.in_optional, exp.byte_index,
                             exp.packet_type, exp.data_length, exp.optional_length);
                    $display("%0t                  got kind %0d byte %02h opt %0b idx %0d type %02h len %0d/%0d pad %02h",
                             $time, got.kind, got.payload_byte, got.in_optional, got.byte_index,
                             got.packet_type, got.data_length, got.optional_length, pad);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : observe
        bit      produced;
        result_t got;
        result_t predicted;
        if (!rst_n)
        begin
            sync_byte  = SYNC_RESET;
            stage      = PH_HUNT;
            hdr_count  = '0;
            crc_acc    = '0;
            held_dlen  = '0;
            held_olen  = '0;
            held_ptype = '0;
            pay_count  = '0;
            awaited_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind            = kind_t'(m_tuser[2:0]);
                got.in_optional     = m_tuser[3];
                got.payload_byte    = m_tdata[7:0];
                got.byte_index      = m_tdata[24:8];
                got.packet_type     = m_tdata[32:25];
                got.data_length     = m_tdata[48:33];
                got.optional_length = m_tdata[56:49];
                compare_result(got, m_tdata[63:57]);
            end
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tdata, produced, predicted);
                if (produced)
                begin
                    awaited_results.push_back(predicted);
                end
            end
            // a write at this edge only affects later bytes
            if (cfg_we)
            begin
                sync_byte = cfg_wdata;
            end
            pending_count = awaited_results.size();
        end
    end

endmodule

@@ bench/sync_header_crc8_packet_deframer_core_test.sv @@
// sync_header_crc8_packet_deframer_core_test: stimulus and verdict for the packet deframer
`timescale 1ns / 1ps

module sync_header_crc8_packet_deframer_core_test;

    import schpd_pkg::*;

    // receiver hold-off that forces the skid stage full and back-pressures the input
    localparam int HOLD_CYCLES = 400;
    // run limit in ns, far beyond the slowest correct run
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;             // [7:0] payload_byte, [24:8] byte_index,
                                      // [32:25] packet_type, [48:33] data_length,
                                      // [56:49] optional_length, rest zero
    logic [3:0]  m_tuser;             // [2:0] kind, [3] in_optional

    // idle mix in percent per cycle, changed between phases
    int          tx_idle_pct = 32;
    int          rx_idle_pct = 65;
    logic        hold_off    = 1'b0;
    bit          hold_request = 1'b0;

    // sync byte the block currently looks for, mirrored for building frames
    logic [7:0]  sync_now = SYNC_RESET;
    int          frames_sent = 0;
    int          frame_bytes = 0;

    int          mismatch_count;
    int          pending_count;
    int          results_seen;

    sync_header_crc8_packet_deframer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deframer_result_checker results_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count),
        .results_seen  (results_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver side: random stalls, or a solid hold-off while one is requested
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering meanwhile
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // offers one byte and returns just after the edge that took it; tready is
    // sampled at the falling edge, where it is settled
    task automatic offer_byte(input logic [7:0] b);
        bit ready_seen;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        ready_seen = 1'b0;
        while (!ready_seen)
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
    endtask

    task automatic send_counted(input logic [7:0] b);
        offer_byte(b);
        frame_bytes++;
    endtask

    // payload bias: the sync byte inside a packet and both byte extremes come up often
    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0:       return sync_now;
            1:       return 8'h00;
            2:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one frame: sync, length high/low, optional length, type, header crc,
    // then payload and data crc when the header is good and the total is not zero
    task automatic send_frame(input logic [15:0] dlen, input logic [7:0] olen,
                              input logic [7:0] ptype, input bit bad_hdr, input bit bad_data);
        logic [31:0] hdr;
        logic [7:0]  crc;
        logic [7:0]  pb;
        int          span;
        hdr  = {dlen, olen, ptype};
        crc  = 8'h00;
        span = int'(dlen) + int'(olen);
        send_counted(sync_now);
        for (int i = 0; i < 4; i++)
        begin
            send_counted(hdr[31 - 8 * i -: 8]);
            crc = crc8_update(crc, hdr[31 - 8 * i -: 8]);
        end
        if (bad_hdr)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_counted(crc);
        if (!bad_hdr && span != 0)
        begin
            crc = 8'h00;
            for (int i = 0; i < span; i++)
            begin
                pb = pick_payload();
                send_counted(pb);
                crc = crc8_update(crc, pb);
            end
            if (bad_data)
            begin
                crc = crc ^ 8'($urandom_range(1, 255));
            end
            send_counted(crc);
        end
        frames_sent++;
    endtask

    // mostly well-formed frames with random content, the rest noise,
    // cut-off headers, header crc errors and empty frames
    task automatic random_traffic(input int quota);
        int start;
        int n;
        int pick;
        start = frame_bytes;
        while (frame_bytes - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // line noise while hunting; an accidental sync byte is fine too
                n = $urandom_range(1, 3);
                repeat (n) offer_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 16)
            begin
                // header cut short, the next frame's bytes then land in it
                send_counted(sync_now);
                n = $urandom_range(0, 3);
                repeat (n) send_counted(8'($urandom_range(0, 255)));
            end
            else if (pick < 24)
            begin
                send_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            else if (pick < 30)
            begin
                send_frame(16'd0, 8'd0, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            else
            begin
                send_frame(16'($urandom_range(0, 12)), 8'($urandom_range(0, 6)),
                           8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 99) < 12);
            end
        end
    endtask

    // input closed until every awaited result is out, then the pipe is left to settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_count != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sync_now  = v;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed frames on the reset sync byte
        offer_byte(8'hFF);                                  // dropped while hunting
        send_frame(16'd0, 8'd0, 8'hA5, 1'b0, 1'b0);         // empty packet
        send_frame(16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b0);     // header crc error, all ones
        send_frame(16'd1, 8'd0, sync_now, 1'b0, 1'b0);      // good, sync byte as type
        send_frame(16'd0, 8'd1, 8'h00, 1'b0, 1'b1);         // data crc error, optional only

        // sender idles 32 %, receiver 65 %, sync byte all zeros
        write_sync(8'h00);
        random_traffic(330);

        // the other way round, sync byte all ones
        write_sync(8'hFF);
        tx_idle_pct = 65;
        rx_idle_pct <= 32;
        random_traffic(330);

        // no idling; a long frame runs into the receiver hold-off
        write_sync(8'($urandom_range(1, 254)));
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_request = 1'b1;
        send_frame(16'h0101, 8'd6, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
        random_traffic(330);

        drain();
        @(negedge clk);
        $display("covered %0d frames in %0d bytes, sync bytes 55, 00, ff and %02h",
                 frames_sent, frame_bytes, sync_now);
        $display("compared %0d result items under mixed stalls and a %0d-cycle hold-off",
                 results_seen, HOLD_CYCLES);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
